// ----- src/lrdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_pkg
// Shared types and constants of the log record deframer and checker.
// ----------------------------------------------------------------------------
package lrdc_pkg;

    localparam int unsigned IN_W  = 40;   // data_byte, file_length
    localparam int unsigned OUT_W = 288;  // tdata fields packed, byte padded
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [2:0] REG_MAX_FILE    = 3'd0;
    localparam logic [2:0] REG_MAX_COUNT   = 3'd1;
    localparam logic [2:0] REG_MAX_PAYLOAD = 3'd2;
    localparam logic [2:0] REG_TYPE_LOW    = 3'd3;
    localparam logic [2:0] REG_TYPE_HIGH   = 3'd4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_FILE_OK = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_TRUNC   = 3'd0;
    localparam logic [2:0] ERR_SIG     = 3'd1;
    localparam logic [2:0] ERR_VERSION = 3'd2;
    localparam logic [2:0] ERR_LENGTH  = 3'd3;
    localparam logic [2:0] ERR_VALUE   = 3'd4;
    localparam logic [2:0] ERR_CRC     = 3'd5;

    localparam logic [31:0] HDR_BYTES  = 32'd16;
    localparam logic [31:0] REC_MIN    = 32'd40;
    localparam logic [31:0] REC_FIXED  = 32'd36;
    localparam logic [31:0] PSIZE_OFF  = 32'd32;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RECORD = 3'b010,
        PH_DROP   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] record_type;
        logic [63:0] sequence_number;
        logic [63:0] transaction_number;
        logic [31:0] page_number;
        logic [31:0] generation_number;
        logic [31:0] payload_length;
        logic [2:0]  error_code;
        logic [31:0] error_offset;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [31:0] max_file_bytes;
        logic [31:0] max_record_count;
        logic [31:0] max_payload_bytes;
        logic [15:0] type_lowest;
        logic [15:0] type_highest;
    } cfg_t;

    // Signature byte at header position p
    function automatic logic [7:0] sig_byte(input logic [2:0] p);
        logic [7:0] v;
        case (p)
            3'd0:    v = 8'h51;
            3'd1:    v = 8'h46;
            3'd2:    v = 8'h57;
            3'd3:    v = 8'h41;
            3'd4:    v = 8'h4C;
            3'd5:    v = 8'h31;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        return x;
    endfunction

    // Data fields of a result, lowest first; kind and last_of_run travel apart
    function automatic logic [OUT_W-1:0] pack_data(input result_t r);
        return {5'd0, r.error_offset, r.error_code, r.payload_length,
                r.generation_number, r.page_number, r.transaction_number,
                r.sequence_number, r.record_type, r.payload_byte};
    endfunction

endpackage
`default_nettype wire

// ----- src/lrdc_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_parser
// Per-byte parse state and checks; yields up to two results per item.
// ----------------------------------------------------------------------------
module lrdc_parser (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    step,
    input  wire [7:0]              data_byte,
    input  wire [31:0]             file_length,
    input  lrdc_pkg::cfg_t         cfg,
    output lrdc_pkg::result_t      res0,
    output lrdc_pkg::result_t      res1,
    output logic [1:0]             res_count
);
    import lrdc_pkg::*;

    logic [31:0] fpos_reg, roff_reg, rstart_reg, rlen_reg, left_reg;
    logic [63:0] prev_seq_reg, seq_reg, trans_reg;
    logic [31:0] page_reg, gen_reg, psize_reg, ver_reg, crc_reg, scrc_reg;
    logic [15:0] type_reg;
    phase_t      phase_reg;

    logic [31:0] fpos_next, roff_next, rstart_next, rlen_next, left_next;
    logic [63:0] prev_seq_next, seq_next, trans_next;
    logic [31:0] page_next, gen_next, psize_next, ver_next, crc_next, scrc_next;
    logic [15:0] type_next;
    phase_t      phase_next;

    result_t     r0, r1;
    logic [1:0]  n;
    logic [31:0] p, r, start, body_end;
    logic [1:0]  bsel;
    logic [1:0]  csel;

    // Parse one byte
    always_comb
    begin
        fpos_next = fpos_reg; roff_next = roff_reg; rstart_next = rstart_reg;
        rlen_next = rlen_reg; left_next = left_reg; prev_seq_next = prev_seq_reg;
        seq_next = seq_reg; trans_next = trans_reg; page_next = page_reg;
        gen_next = gen_reg; psize_next = psize_reg; ver_next = ver_reg;
        crc_next = crc_reg; scrc_next = scrc_reg; type_next = type_reg;
        phase_next = phase_reg;
        r0 = '0; r1 = '0; n = 2'd0;
        p = fpos_reg;
        r = roff_reg;
        start = fpos_reg + 32'd1;
        body_end = rlen_reg - 32'd4;
        bsel = r[1:0];
        // byte lane of the stored CRC, counted from the end of the body
        csel = r[1:0] - body_end[1:0];

        if (phase_reg == PH_HEADER) begin
            if (p == 32'd0 && file_length < HDR_BYTES) begin
                r0.kind = KIND_ERROR; r0.error_code = ERR_TRUNC; n = 2'd1;
                phase_next = PH_DROP;
            end else if (p == 32'd0 && file_length > cfg.max_file_bytes) begin
                r0.kind = KIND_ERROR; r0.error_code = ERR_SIG; n = 2'd1;
                phase_next = PH_DROP;
            end else if (p < 32'd8) begin
                if (data_byte != sig_byte(p[2:0])) begin
                    r0.kind = KIND_ERROR; r0.error_code = ERR_SIG; n = 2'd1;
                    phase_next = PH_DROP;
                end
            end else if (p < 32'd12) begin
                ver_next[8*p[1:0] +: 8] = data_byte;
            end else if (p < HDR_BYTES) begin
                left_next[8*p[1:0] +: 8] = data_byte;
                if (p == 32'd15) begin
                    if (ver_reg != 32'd1 || left_next > cfg.max_record_count) begin
                        r0.kind = KIND_ERROR; r0.error_code = ERR_VERSION;
                        r0.error_offset = 32'd8; n = 2'd1;
                        phase_next = PH_DROP;
                    end else if (left_next == 32'd0) begin
                        n = 2'd1; phase_next = PH_DROP;
                        if (start == file_length) r0.kind = KIND_FILE_OK;
                        else begin
                            r0.kind = KIND_ERROR; r0.error_code = ERR_LENGTH;
                            r0.error_offset = start;
                        end
                    end else if (file_length < start || file_length - start < REC_MIN) begin
                        r0.kind = KIND_ERROR; r0.error_code = ERR_TRUNC;
                        r0.error_offset = start; n = 2'd1; phase_next = PH_DROP;
                    end else begin
                        phase_next = PH_RECORD; rstart_next = start; roff_next = '0;
                        rlen_next = '0; seq_next = '0; trans_next = '0; page_next = '0;
                        gen_next = '0; psize_next = '0; type_next = '0;
                        crc_next = '1; scrc_next = '0;
                    end
                end
            end
        end else if (phase_reg == PH_RECORD) begin
            roff_next = r + 32'd1;
            if (r >= 32'd4 && (r < REC_FIXED || r < body_end))
                crc_next = crc_byte(crc_reg, data_byte);
            if (r < 32'd4) begin
                rlen_next[8*bsel +: 8] = data_byte;
                if (r == 32'd3 && (rlen_next < REC_MIN
                                   || rlen_next > file_length - rstart_reg)) begin
                    r0.kind = KIND_ERROR; r0.error_code = ERR_LENGTH;
                    r0.error_offset = rstart_reg; n = 2'd1; phase_next = PH_DROP;
                end
            end else if (r < 32'd6) begin
                type_next[8*r[0] +: 8] = data_byte;
                if (r == 32'd5 && (type_next < cfg.type_lowest
                                   || type_next > cfg.type_highest)) begin
                    r0.kind = KIND_ERROR; r0.error_code = ERR_VALUE;
                    r0.error_offset = rstart_reg + 32'd4; n = 2'd1;
                    phase_next = PH_DROP;
                end
            end else if (r < 32'd8) begin
                // reserved
            end else if (r < 32'd16) begin
                seq_next[8*r[2:0] +: 8] = data_byte;
            end else if (r < 32'd24) begin
                trans_next[8*r[2:0] +: 8] = data_byte;
            end else if (r < 32'd28) begin
                page_next[8*bsel +: 8] = data_byte;
            end else if (r < PSIZE_OFF) begin
                gen_next[8*bsel +: 8] = data_byte;
            end else if (r < REC_FIXED) begin
                psize_next[8*bsel +: 8] = data_byte;
                if (r == 32'd35 && (psize_next > cfg.max_payload_bytes
                        || ({1'b0, psize_next} + 33'd40) != {1'b0, rlen_reg})) begin
                    r0.kind = KIND_ERROR; r0.error_code = ERR_LENGTH;
                    r0.error_offset = rstart_reg + PSIZE_OFF; n = 2'd1;
                    phase_next = PH_DROP;
                end
            end else if (r < body_end) begin
                r0.kind = KIND_PAYLOAD; r0.payload_byte = data_byte; n = 2'd1;
            end else begin
                scrc_next[8*csel +: 8] = data_byte;
                if (r == rlen_reg - 32'd1) begin
                    if (scrc_next != ~crc_reg) begin
                        r0.kind = KIND_ERROR; r0.error_code = ERR_CRC;
                        r0.error_offset = rstart_reg + body_end; n = 2'd1;
                        phase_next = PH_DROP;
                    end else if (seq_reg == 64'd0 || seq_reg <= prev_seq_reg) begin
                        r0.kind = KIND_ERROR; r0.error_code = ERR_VALUE;
                        r0.error_offset = rstart_reg + 32'd8; n = 2'd1;
                        phase_next = PH_DROP;
                    end else begin
                        r0.kind = KIND_RECORD; r0.record_type = type_reg;
                        r0.sequence_number = seq_reg; r0.transaction_number = trans_reg;
                        r0.page_number = page_reg; r0.generation_number = gen_reg;
                        r0.payload_length = psize_reg; n = 2'd2;
                        prev_seq_next = seq_reg;
                        left_next = left_reg - 32'd1;
                        if (left_next == 32'd0) begin
                            phase_next = PH_DROP;
                            if (start == file_length) r1.kind = KIND_FILE_OK;
                            else begin
                                r1.kind = KIND_ERROR; r1.error_code = ERR_LENGTH;
                                r1.error_offset = start;
                            end
                        end else if (file_length < start
                                     || file_length - start < REC_MIN) begin
                            r1.kind = KIND_ERROR; r1.error_code = ERR_TRUNC;
                            r1.error_offset = start; phase_next = PH_DROP;
                        end else begin
                            n = 2'd1;
                            rstart_next = start; roff_next = '0;
                            rlen_next = '0; seq_next = '0; trans_next = '0;
                            page_next = '0; gen_next = '0; psize_next = '0;
                            type_next = '0; crc_next = '1; scrc_next = '0;
                        end
                    end
                end
            end
        end

        // File end: report truncation if nothing concluded, then clear
        if ({1'b0, fpos_reg} + 33'd1 >= {1'b0, file_length}) begin
            if (phase_next != PH_DROP && n < 2'd2) begin
                if (n == 2'd0) begin
                    r0 = '0; r0.kind = KIND_ERROR; r0.error_code = ERR_TRUNC;
                    r0.error_offset = start;
                end else begin
                    r1 = '0; r1.kind = KIND_ERROR; r1.error_code = ERR_TRUNC;
                    r1.error_offset = start;
                end
                n = n + 2'd1;
            end
            fpos_next = '0; roff_next = '0; rstart_next = '0; rlen_next = '0;
            left_next = '0; prev_seq_next = '0; seq_next = '0; trans_next = '0;
            page_next = '0; gen_next = '0; psize_next = '0; type_next = '0;
            ver_next = '0; crc_next = '1; scrc_next = '0; phase_next = PH_HEADER;
        end else begin
            fpos_next = start;
        end

        if (n == 2'd1) r0.last_of_run = 1'b1;
        if (n == 2'd2) r1.last_of_run = 1'b1;
    end

    assign res0 = r0;
    assign res1 = r1;
    assign res_count = n;

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fpos_reg <= '0; roff_reg <= '0; rstart_reg <= '0; rlen_reg <= '0;
            left_reg <= '0; prev_seq_reg <= '0; seq_reg <= '0; trans_reg <= '0;
            page_reg <= '0; gen_reg <= '0; psize_reg <= '0; type_reg <= '0;
            ver_reg <= '0; crc_reg <= '1; scrc_reg <= '0; phase_reg <= PH_HEADER;
        end else if (step) begin
            fpos_reg <= fpos_next; roff_reg <= roff_next; rstart_reg <= rstart_next;
            rlen_reg <= rlen_next; left_reg <= left_next; prev_seq_reg <= prev_seq_next;
            seq_reg <= seq_next; trans_reg <= trans_next; page_reg <= page_next;
            gen_reg <= gen_next; psize_reg <= psize_next; type_reg <= type_next;
            ver_reg <= ver_next; crc_reg <= crc_next; scrc_reg <= scrc_next;
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/lrdc_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrdc_out_queue
// Four-entry result queue; takes one or two results per cycle.
// ----------------------------------------------------------------------------
module lrdc_out_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [1:0]                    push_count,
    input  lrdc_pkg::result_t            push0,
    input  lrdc_pkg::result_t            push1,
    output logic                         room,
    output logic                         tvalid,
    input  wire                          tready,
    output lrdc_pkg::result_t            head
);
    import lrdc_pkg::*;

    result_t    mem_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop = tvalid && tready;
    assign tvalid = cnt_reg != 3'd0;
    assign head = mem_reg[rd_reg];
    // Space for two more results without counting on this cycle's pop
    assign room = cnt_reg <= 3'd2;
    assign cnt_next = cnt_reg + {1'b0, push_count} - {2'd0, pop};

    // Storage
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) mem_reg[wr_reg] <= push0;
        if (push_count == 2'd2) mem_reg[wr_reg + 2'd1] <= push1;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg <= '0; wr_reg <= '0; cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_reg + {1'b0, pop};
            wr_reg  <= wr_reg + push_count;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/log_record_deframer_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// log_record_deframer_checker
// Deframes and checks a byte-streamed log file, emitting payload and status.
// ----------------------------------------------------------------------------
// A result is written into the output queue as its byte is accepted and
// shows on m_axis in the following cycle when nothing waits ahead of it.
// Throughput: one byte per cycle while the queue has room; a byte yields at
// most two results, drained from a four-entry queue at one per cycle while
// m_axis_tready is high; s_axis stalls while three or more results wait.
// Reset: asynchronous, clears parse state to the file header and restores
// all configuration registers to their defaults.
module log_record_deframer_checker (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [39:0]   s_axis_tdata,  // data_byte[7:0], file_length[39:8]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [287:0] m_axis_tdata,  // payload_byte, record_type,
                                        // sequence_number, transaction_number,
                                        // page_number, generation_number,
                                        // payload_length, error_code,
                                        // error_offset, pad
    output logic [1:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast,  // last_of_run
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [2:0]    cfg_index,
    input  wire [31:0]   cfg_data
);
    import lrdc_pkg::*;

    cfg_t       cfg_reg;
    result_t    res0, res1, head;
    logic [1:0] cnt;
    logic       step, room;

    assign s_axis_tready = room;
    assign cfg_ready = 1'b1;
    assign step = s_axis_tvalid && room;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.max_file_bytes    <= '1;
            cfg_reg.max_record_count  <= '1;
            cfg_reg.max_payload_bytes <= '1;
            cfg_reg.type_lowest       <= '0;
            cfg_reg.type_highest      <= '1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_FILE:    cfg_reg.max_file_bytes    <= cfg_data;
                REG_MAX_COUNT:   cfg_reg.max_record_count  <= cfg_data;
                REG_MAX_PAYLOAD: cfg_reg.max_payload_bytes <= cfg_data;
                REG_TYPE_LOW:    cfg_reg.type_lowest       <= cfg_data[15:0];
                REG_TYPE_HIGH:   cfg_reg.type_highest      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    lrdc_parser u_parser (
        .clk(clk), .rst_n(rst_n), .step(step),
        .data_byte(s_axis_tdata[7:0]), .file_length(s_axis_tdata[39:8]),
        .cfg(cfg_reg), .res0(res0), .res1(res1), .res_count(cnt)
    );

    lrdc_out_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_count(step ? cnt : 2'd0),
        .push0(res0), .push1(res1),
        .room(room), .tvalid(m_axis_tvalid), .tready(m_axis_tready),
        .head(head)
    );

    // Result item onto the master side
    assign m_axis_tdata = pack_data(head);
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;

    // Checks
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> !s_axis_tready) else $error("accept while queue full");
    a_two_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (step && cnt == 2'd2) |=> m_axis_tvalid) else $error("results lost");
    a_last_on_single: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt == 2'd1) |-> res0.last_of_run) else $error("last flag missing");

endmodule
`default_nettype wire

// ----- sim/tb_log_record_deframer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_record_deframer_checker
// Streams generated log files through the deframer, predicts every result
// with an in-bench model of the parser and compares each returned item.
// ----------------------------------------------------------------------------
module tb_log_record_deframer_checker;
    import lrdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    log_record_deframer_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Bench copies of the configuration registers
    logic [31:0] lim_file, lim_count, lim_payload;
    logic [15:0] type_lo, type_hi;

    // Parser state mirror
    logic [31:0] f_pos, r_off, r_start, r_len, rec_left, ver_word;
    logic [63:0] prev_seq, cur_seq, cur_tx;
    logic [31:0] cur_page, cur_gen, cur_psz, crc_run, crc_got;
    logic [15:0] cur_type;
    phase_t      phase;

    result_t     step_out[$];
    result_t     expected_results[$];
    logic [39:0] pending_bytes[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_left;
    bit  s_took;
    int  mismatches;
    int  quiet_cycles;
    int  items_sent;

    logic [7:0] sig_ref[8] = '{8'h51, 8'h46, 8'h57, 8'h41, 8'h4C, 8'h31, 8'h00, 8'h00};

    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
        return x;
    endfunction

    task automatic report_error(input logic [2:0] code, input logic [31:0] off);
        result_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        r.error_offset = off;
        step_out.insert(step_out.size(), r);
        phase = PH_DROP;
    endtask

    task automatic reset_file_state();
        f_pos = '0; r_off = '0; r_start = '0; r_len = '0; rec_left = '0;
        prev_seq = '0; cur_seq = '0; cur_tx = '0; cur_page = '0; cur_gen = '0;
        cur_psz = '0; cur_type = '0; ver_word = '0; crc_run = '1; crc_got = '0;
        phase = PH_HEADER;
    endtask

    // Decide what follows the header or a finished record
    task automatic open_next(input logic [31:0] size);
        logic [31:0] start;
        result_t r;
        start = f_pos + 32'd1;
        if (rec_left == 0)
        begin
            if (start == size)
            begin
                r = '0;
                r.kind = KIND_FILE_OK;
                step_out.insert(step_out.size(), r);
                phase = PH_DROP;
            end
            else
                report_error(ERR_LENGTH, start);
            return;
        end
        if (size < start || size - start < 32'd40)
        begin
            report_error(ERR_TRUNC, start);
            return;
        end
        phase = PH_RECORD;
        r_start = start;
        r_off = '0; r_len = '0; cur_seq = '0; cur_tx = '0; cur_page = '0;
        cur_gen = '0; cur_psz = '0; cur_type = '0; crc_run = '1; crc_got = '0;
    endtask

    task automatic header_in(input logic [7:0] b, input logic [31:0] size);
        logic [31:0] p;
        p = f_pos;
        if (p == 0)
        begin
            if (size < 32'd16)
            begin
                report_error(ERR_TRUNC, 32'd0);
                return;
            end
            if (size > lim_file)
            begin
                report_error(ERR_SIG, 32'd0);
                return;
            end
        end
        if (p < 8)
        begin
            if (b != sig_ref[p]) report_error(ERR_SIG, 32'd0);
        end
        else if (p < 12)
            ver_word |= {24'd0, b} << (8 * (p - 8));
        else if (p < 16)
        begin
            rec_left |= {24'd0, b} << (8 * (p - 12));
            if (p == 15)
            begin
                if (ver_word != 32'd1 || rec_left > lim_count)
                    report_error(ERR_VERSION, 32'd8);
                else
                    open_next(size);
            end
        end
    endtask

    task automatic record_in(input logic [7:0] b, input logic [31:0] size);
        logic [31:0] r;
        result_t o;
        r = r_off;
        r_off = r_off + 32'd1;
        if (r >= 4 && (r < 36 || r < r_len - 32'd4))
            crc_run = crc_next(crc_run, b);
        if (r < 4)
        begin
            r_len |= {24'd0, b} << (8 * r);
            if (r == 3 && (r_len < 32'd40 || r_len > size - r_start))
                report_error(ERR_LENGTH, r_start);
        end
        else if (r < 6)
        begin
            cur_type |= {8'd0, b} << (8 * (r - 4));
            if (r == 5 && (cur_type < type_lo || cur_type > type_hi))
                report_error(ERR_VALUE, r_start + 32'd4);
        end
        else if (r < 8)
        begin
            // reserved field
        end
        else if (r < 16)
            cur_seq |= {56'd0, b} << (8 * (r - 8));
        else if (r < 24)
            cur_tx |= {56'd0, b} << (8 * (r - 16));
        else if (r < 28)
            cur_page |= {24'd0, b} << (8 * (r - 24));
        else if (r < 32)
            cur_gen |= {24'd0, b} << (8 * (r - 28));
        else if (r < 36)
        begin
            cur_psz |= {24'd0, b} << (8 * (r - 32));
            if (r == 35 && (cur_psz > lim_payload ||
                            {32'd0, cur_psz} + 64'd40 != {32'd0, r_len}))
                report_error(ERR_LENGTH, r_start + 32'd32);
        end
        else if (r < r_len - 32'd4)
        begin
            o = '0;
            o.kind = KIND_PAYLOAD;
            o.payload_byte = b;
            step_out.insert(step_out.size(), o);
        end
        else
        begin
            crc_got |= {24'd0, b} << (8 * ((r - (r_len - 32'd4)) & 32'd3));
            if (r == r_len - 32'd1)
            begin
                if (crc_got != ~crc_run)
                begin
                    report_error(ERR_CRC, r_start + r_len - 32'd4);
                    return;
                end
                if (cur_seq == 0 || cur_seq <= prev_seq)
                begin
                    report_error(ERR_VALUE, r_start + 32'd8);
                    return;
                end
                o = '0;
                o.kind = KIND_RECORD;
                o.record_type = cur_type;
                o.sequence_number = cur_seq;
                o.transaction_number = cur_tx;
                o.page_number = cur_page;
                o.generation_number = cur_gen;
                o.payload_length = cur_psz;
                step_out.insert(step_out.size(), o);
                prev_seq = cur_seq;
                rec_left = rec_left - 32'd1;
                open_next(size);
            end
        end
    endtask

    // Expected results of one accepted byte
    task automatic predict_byte(input logic [39:0] item);
        logic [7:0]  b;
        logic [31:0] size;
        result_t     r;
        b = item[7:0];
        size = item[39:8];
        step_out.delete();
        if (phase == PH_HEADER)
            header_in(b, size);
        else if (phase == PH_RECORD)
            record_in(b, size);
        if ({32'd0, f_pos} + 64'd1 >= {32'd0, size})
        begin
            if (phase != PH_DROP && step_out.size() < 2)
                report_error(ERR_TRUNC, f_pos + 32'd1);
            reset_file_state();
        end
        else
            f_pos = f_pos + 32'd1;
        foreach (step_out[i])
        begin
            r = step_out[i];
            r.last_of_run = (i == step_out.size() - 1);
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    function automatic result_t unpack_result(input logic [287:0] d, input logic [1:0] u,
                                              input logic l);
        result_t r;
        r.kind               = u;
        r.payload_byte       = d[7:0];
        r.record_type        = d[23:8];
        r.sequence_number    = d[87:24];
        r.transaction_number = d[151:88];
        r.page_number        = d[183:152];
        r.generation_number  = d[215:184];
        r.payload_length     = d[247:216];
        r.error_code         = d[250:248];
        r.error_offset       = d[282:251];
        r.last_of_run        = l;
        return r;
    endfunction

    // Input driver
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || s_took)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on input items, check output items, watchdog
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        s_took = s_axis_tvalid && s_axis_tready;
        if (s_took)
            predict_byte(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = unpack_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        if (s_took || (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (pending_bytes.size() > 0 || expected_results.size() > 0 || s_axis_tvalid
                 || cfg_valid)
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("log_record_deframer_checker regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAX_FILE:    lim_file = val;
            REG_MAX_COUNT:   lim_count = val;
            REG_MAX_PAYLOAD: lim_payload = val;
            REG_TYPE_LOW:    type_lo = val[15:0];
            REG_TYPE_HIGH:   type_hi = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(input logic [31:0] fmax, input logic [31:0] cmax,
                              input logic [31:0] pmax, input logic [15:0] tlo,
                              input logic [15:0] thi);
        wait_drained();
        write_reg(REG_MAX_FILE, fmax);
        write_reg(REG_MAX_COUNT, cmax);
        write_reg(REG_MAX_PAYLOAD, pmax);
        write_reg(REG_TYPE_LOW, {16'd0, tlo});
        write_reg(REG_TYPE_HIGH, {16'd0, thi});
    endtask

    task automatic queue_bytes(input logic [7:0] fb[$], input logic [31:0] len);
        foreach (fb[i])
            pending_bytes.insert(pending_bytes.size(), {len, fb[i]});
        items_sent += fb.size();
    endtask

    function automatic void put_le(ref logic [7:0] fb[$], input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            fb.insert(fb.size(), v[8*i +: 8]);
    endfunction

    // Build one log file, well formed in some draws and damaged in most
    task automatic queue_log_file();
        logic [7:0]  fb[$];
        logic [7:0]  body[$];
        logic [31:0] crc;
        logic [63:0] seq;
        logic [15:0] t;
        int nrec, pl, damage, cnt, n;
        fb.delete();
        nrec = $urandom_range(4);
        damage = $urandom_range(9);
        cnt = nrec;
        if (damage == 6) cnt = nrec + $urandom_range(1) * 2 - 1;
        for (int i = 0; i < 8; i++) fb.insert(fb.size(), sig_ref[i]);
        put_le(fb, (damage == 7) ? {$urandom, $urandom} : 64'd1, 4);
        put_le(fb, cnt, 4);
        seq = {$urandom_range(3) == 0 ? 32'hFFFFFFFF : 32'd0, $urandom};
        for (int k = 0; k < nrec; k++)
        begin
            pl = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
            seq = seq + $urandom_range(1000, 1);
            if (type_lo <= type_hi && $urandom_range(7) != 0)
                t = $urandom_range(type_hi, type_lo);
            else
                t = $urandom;
            body.delete();
            put_le(body, t, 2);
            put_le(body, $urandom, 2);
            put_le(body, seq, 8);
            put_le(body, {$urandom, $urandom}, 8);
            put_le(body, $urandom, 4);
            put_le(body, $urandom, 4);
            put_le(body, pl, 4);
            for (int j = 0; j < pl; j++) body.insert(body.size(), 8'($urandom));
            crc = 32'hFFFFFFFF;
            foreach (body[j]) crc = crc_next(crc, body[j]);
            put_le(fb, 40 + pl, 4);
            foreach (body[j]) fb.insert(fb.size(), body[j]);
            put_le(fb, ~crc, 4);
        end
        case (damage)
            0, 1:
            begin
                n = $urandom_range(fb.size() - 1);
                fb[n] = fb[n] ^ (8'd1 << $urandom_range(7));
            end
            2:
            begin
                n = $urandom_range(fb.size() - 1, 1);
                while (fb.size() > n) void'(fb.pop_back());
            end
            3:
            begin
                n = $urandom_range(3, 1);
                repeat (n) fb.insert(fb.size(), 8'($urandom));
            end
            default: ;
        endcase
        if (damage == 8)
        begin
            // lengths that change within the file, the last byte closes it
            n = fb.size();
            for (int i = 0; i < n - 1; i++)
                pending_bytes.insert(pending_bytes.size(), {$urandom, fb[i]});
            pending_bytes.insert(pending_bytes.size(), {n[31:0], fb[n-1]});
            items_sent += n;
        end
        else
            queue_bytes(fb, fb.size());
    endtask

    task automatic run_phase(input int idle, input int stall, input int nitems);
        int goal;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        goal = items_sent + nitems;
        while (items_sent < goal)
        begin
            queue_log_file();
            if (pending_bytes.size() > 200) wait_drained();
        end
    endtask

    initial
    begin
        logic [7:0] fb[$];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_took = 1'b0;
        hold_left = 0;
        mismatches = 0;
        quiet_cycles = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        lim_file = '1; lim_count = '1; lim_payload = '1; type_lo = '0; type_hi = '1;
        reset_file_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty log, one-byte file, two-byte file, odd lengths
        set_limits('1, '1, '1, 16'd0, 16'hFFFF);
        fb = '{8'h51, 8'h46, 8'h57, 8'h41, 8'h4C, 8'h31, 8'h00, 8'h00,
               8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_bytes(fb, 32'd16);
        fb = '{8'hFF};
        queue_bytes(fb, 32'd1);
        fb = '{8'h00, 8'hAA};
        queue_bytes(fb, 32'd2);
        pending_bytes.insert(pending_bytes.size(), {32'hFFFFFFFF, 8'h51});
        pending_bytes.insert(pending_bytes.size(), {32'h00000002, 8'h46});
        items_sent += 2;
        wait_drained();

        // Extremes: all limits zero, so every file is rejected at once, then a type range of one value
        set_limits('0, '0, '0, 16'd0, 16'd0);
        run_phase(0, 0, 60);
        set_limits('1, '1, '1, 16'hFFFF, 16'hFFFF);
        run_phase(0, 0, 60);

        // Random phases over the idling mixes
        set_limits('1, '1, '1, 16'd0, 16'hFFFF);
        run_phase(0, 0, 300);
        set_limits($urandom_range(600, 16), $urandom_range(5, 1), $urandom_range(20),
                   $urandom_range(1000), $urandom_range(65535, 30000));
        run_phase(88, 0, 300);
        set_limits($urandom, $urandom_range(4, 2), $urandom_range(40, 4),
                   $urandom, $urandom);
        run_phase(0, 88, 300);
        set_limits('1, 32'd3, 32'd8, 16'd0, 16'hFFFF);
        run_phase(13, 13, 300);

        // Long receiver hold-off while the sender keeps offering
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_log_file();
        queue_log_file();
        hold_left = HOLD_CYCLES;
        wait_drained();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("log_record_deframer_checker regression: pass");
        else
            $display("log_record_deframer_checker regression: fail");
        $finish;
    end

endmodule
